/* src/named_multi_stack_pool_macros.svh */
// Assertion macros shared by the named stack pool RTL.
// No dependencies; include with the bare file name.
`ifndef NAMED_MULTI_STACK_POOL_MACROS_SVH
`define NAMED_MULTI_STACK_POOL_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define MSP_ASSERT(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
    else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MSP_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MSP_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/msp_pkg.sv */
// Shared types and constants for the named stack pool.
// No dependencies.
package msp_pkg;

  // Fixed port field widths
  localparam int OP_W     = 2;
  localparam int TAG_W    = 64;
  localparam int WORD_W   = 64;
  localparam int STATUS_W = 3;

  // Parameter defaults
  localparam int DEF_MAX_STACKS = 16;
  localparam int DEF_POOL_DEPTH = 64;
  localparam int DEF_ITEM_WIDTH = 64;
  localparam int DEF_NAME_WIDTH = 64;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE = 2'd0,
    OP_PUSH   = 2'd1,
    OP_POP    = 2'd2,
    OP_LIST   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK_ITEM = 3'd0,
    ST_OK_NONE = 3'd1,
    ST_EMPTY   = 3'd2,
    ST_UNKNOWN = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  // Controller to datapath commands
  typedef struct packed {
    logic    load_req;
    logic    find;
    logic    create;
    logic    push;
    logic    list_start;
    logic    pop;
    logic    list_emit;
    logic    emit_err;
    status_e err_status;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    op_e  op;
    logic found;
    logic top_null;
    logic walk_last;
    logic out_free;
  } stat_t;

endpackage

/* src/msp_req_if.sv */
// Request channel of the named stack pool: valid/ready plus operation fields.
// Depends on msp_pkg.
interface msp_req_if import msp_pkg::*; ();
  logic             valid;
  logic             ready;
  op_e              operation;
  logic [TAG_W-1:0] stack_name;
  logic [WORD_W-1:0] item_in;

  modport source (output valid, operation, stack_name, item_in, input ready);
  modport sink   (input valid, operation, stack_name, item_in, output ready);
endinterface

/* src/msp_rsp_if.sv */
// Result channel of the named stack pool: valid/ready plus result fields.
// Depends on msp_pkg.
interface msp_rsp_if import msp_pkg::*; ();
  logic              valid;
  logic              ready;
  status_e           status;
  logic [WORD_W-1:0] item_out;
  logic              last;

  modport source (output valid, status, item_out, last, input ready);
  modport sink   (input valid, status, item_out, last, output ready);
endinterface

/* src/msp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module msp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* src/msp_datapath.sv */
// Datapath of the named stack pool: name table, top pointers, node pool,
// free list and result register. Depends on msp_pkg, msp_ram and the macros.
`include "named_multi_stack_pool_macros.svh"

module msp_datapath import msp_pkg::*; #(
  parameter int MAX_STACKS = DEF_MAX_STACKS,
  parameter int POOL_DEPTH = DEF_POOL_DEPTH,
  parameter int ITEM_WIDTH = DEF_ITEM_WIDTH,
  parameter int NAME_WIDTH = DEF_NAME_WIDTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  input  op_e               req_operation_i,
  input  logic [TAG_W-1:0]  req_stack_name_i,
  input  logic [WORD_W-1:0] req_item_in_i,
  output logic              rsp_valid_o,
  input  logic              rsp_ready_i,
  output status_e           rsp_status_o,
  output logic [WORD_W-1:0] rsp_item_out_o,
  output logic              rsp_last_o
);

  localparam int SIDX_W = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int CNT_W  = $clog2(MAX_STACKS + 1);
  localparam int PTR_W  = $clog2(POOL_DEPTH + 1);
  localparam int AW     = $clog2(POOL_DEPTH);
  localparam logic [PTR_W-1:0] NULL_PTR  = PTR_W'(POOL_DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_STACKS);
  localparam logic [AW-1:0]    WALK_LAST = AW'(POOL_DEPTH - 1);

  // Latched request
  op_e                   op_q;
  logic [NAME_WIDTH-1:0] name_q;
  logic [ITEM_WIDTH-1:0] item_q;

  // Name table and lookup
  logic [NAME_WIDTH-1:0] tbl_q [MAX_STACKS];
  logic [MAX_STACKS-1:0] match_d, match_q;
  logic [SIDX_W-1:0]     pe_idx, idx_q;
  logic [CNT_W-1:0]      count_q;

  // Pool bookkeeping
  logic [PTR_W-1:0] fresh_q, free_head_q, cur_q;
  logic [AW-1:0]    walk_k_q;

  // RAM read data
  logic [PTR_W-1:0]      tp_rd, link_rd;
  logic [ITEM_WIDTH-1:0] item_rd;

  // Result register
  logic              out_valid_q;
  status_e           out_status_q, out_status_d;
  logic [WORD_W-1:0] out_item_q, out_item_d;
  logic              out_last_q, out_last_d;

  logic             free_null, pool_full, push_ok, create_full, create_ok;
  logic             walk_last, emit, out_free;
  logic [PTR_W-1:0] push_node;

  // Parallel compare of the tag against created entries
  always_comb begin
    for (int i = 0; i < MAX_STACKS; i++) begin
      match_d[i] = (CNT_W'(i) < count_q) && (tbl_q[i] == name_q);
    end
  end

  // Lowest matching entry wins
  always_comb begin
    pe_idx = '0;
    for (int i = MAX_STACKS - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        pe_idx = SIDX_W'(i);
      end
    end
  end

  // Allocation and walk decisions
  assign free_null   = (free_head_q >= NULL_PTR);
  assign pool_full   = free_null && (fresh_q >= NULL_PTR);
  assign push_node   = free_null ? fresh_q : free_head_q;
  assign push_ok     = cmd_i.push && !pool_full;
  assign create_full = (count_q >= CNT_FULL);
  assign create_ok   = cmd_i.create && !create_full;
  assign walk_last   = (link_rd >= NULL_PTR) || (walk_k_q == WALK_LAST);
  assign out_free    = !out_valid_q || rsp_ready_i;
  assign emit        = cmd_i.create || cmd_i.push || cmd_i.pop || cmd_i.list_emit ||
                       cmd_i.emit_err;

  // Top pointer per stack
  msp_ram #(.WIDTH(PTR_W), .DEPTH(MAX_STACKS)) u_top_ram (
    .clk_i     (clk_i),
    .wr_en_i   (create_ok || push_ok || cmd_i.pop),
    .wr_addr_i (cmd_i.create ? count_q[SIDX_W-1:0] : idx_q),
    .wr_data_i (cmd_i.create ? NULL_PTR : (cmd_i.push ? push_node : link_rd)),
    .rd_en_i   (cmd_i.find),
    .rd_addr_i (pe_idx),
    .rd_data_o (tp_rd)
  );

  // Node links, also used as free list links
  msp_ram #(.WIDTH(PTR_W), .DEPTH(POOL_DEPTH)) u_link_ram (
    .clk_i     (clk_i),
    .wr_en_i   (push_ok || cmd_i.pop),
    .wr_addr_i (cmd_i.push ? push_node[AW-1:0] : cur_q[AW-1:0]),
    .wr_data_i (cmd_i.push ? tp_rd : free_head_q),
    .rd_en_i   ((cmd_i.find && !free_null) || cmd_i.list_start || cmd_i.list_emit),
    .rd_addr_i (cmd_i.find ? free_head_q[AW-1:0] :
                (cmd_i.list_start ? tp_rd[AW-1:0] : link_rd[AW-1:0])),
    .rd_data_o (link_rd)
  );

  // Node items
  msp_ram #(.WIDTH(ITEM_WIDTH), .DEPTH(POOL_DEPTH)) u_item_ram (
    .clk_i     (clk_i),
    .wr_en_i   (push_ok),
    .wr_addr_i (push_node[AW-1:0]),
    .wr_data_i (item_q),
    .rd_en_i   (cmd_i.list_start || cmd_i.list_emit),
    .rd_addr_i (cmd_i.list_start ? tp_rd[AW-1:0] : link_rd[AW-1:0]),
    .rd_data_o (item_rd)
  );

  // Next result
  always_comb begin
    out_status_d = ST_OK_NONE;
    out_item_d   = '0;
    out_last_d   = 1'b1;
    priority if (cmd_i.create) begin
      out_status_d = create_full ? ST_FULL : ST_OK_NONE;
    end else if (cmd_i.push) begin
      out_status_d = pool_full ? ST_FULL : ST_OK_NONE;
    end else if (cmd_i.pop) begin
      out_status_d = ST_OK_ITEM;
      out_item_d   = WORD_W'(item_rd);
    end else if (cmd_i.list_emit) begin
      out_status_d = ST_OK_ITEM;
      out_item_d   = WORD_W'(item_rd);
      out_last_d   = walk_last;
    end else if (cmd_i.emit_err) begin
      out_status_d = cmd_i.err_status;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      fresh_q     <= '0;
      free_head_q <= NULL_PTR;
      out_valid_q <= 1'b0;
    end else begin
      if (create_ok) begin
        count_q <= count_q + CNT_W'(1);
      end
      if (push_ok) begin
        if (free_null) begin
          fresh_q <= fresh_q + PTR_W'(1);
        end else begin
          free_head_q <= link_rd;
        end
      end else if (cmd_i.pop) begin
        free_head_q <= cur_q;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    match_q <= match_d;
    if (cmd_i.load_req) begin
      op_q   <= req_operation_i;
      name_q <= req_stack_name_i[NAME_WIDTH-1:0];
      item_q <= req_item_in_i[ITEM_WIDTH-1:0];
    end
    if (create_ok) begin
      tbl_q[count_q[SIDX_W-1:0]] <= name_q;
    end
    if (cmd_i.find) begin
      idx_q <= pe_idx;
    end
    if (cmd_i.list_start) begin
      cur_q    <= tp_rd;
      walk_k_q <= '0;
    end else if (cmd_i.list_emit) begin
      cur_q    <= link_rd;
      walk_k_q <= walk_k_q + AW'(1);
    end
    if (emit) begin
      out_status_q <= out_status_d;
      out_item_q   <= out_item_d;
      out_last_q   <= out_last_d;
    end
  end

  assign stat_o.op        = op_q;
  assign stat_o.found     = |match_q;
  assign stat_o.top_null  = (tp_rd >= NULL_PTR);
  assign stat_o.walk_last = walk_last;
  assign stat_o.out_free  = out_free;

  assign rsp_valid_o    = out_valid_q;
  assign rsp_status_o   = out_status_q;
  assign rsp_item_out_o = out_item_q;
  assign rsp_last_o     = out_last_q;

  // Checks
  `MSP_ASSERT(a_free_below_fresh, clk_i, rst_ni, free_null || (free_head_q < fresh_q), "free list head points past allocated nodes")
  `MSP_ASSERT(a_fresh_bound, clk_i, rst_ni, fresh_q <= NULL_PTR, "fresh node count beyond pool")
  `MSP_ASSERT_IMP(a_emit_free, clk_i, rst_ni, emit, out_free, "result written over a pending result")
  `MSP_ASSERT_NXT(a_emit_valid, clk_i, rst_ni, emit, out_valid_q, "result written but not shown")

endmodule

/* src/msp_ctrl.sv */
// Controller of the named stack pool: sequences lookup, update and list walk.
// Depends on msp_pkg.
module msp_ctrl import msp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MATCH = 5'b00010,
    S_FIND  = 5'b00100,
    S_TOP   = 5'b01000,
    S_READ  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.err_status = ST_OK_ITEM;
    req_ready_o      = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = S_MATCH;
        end
      end
      S_MATCH: begin
        // compare registers this cycle; create needs no lookup
        if (stat_i.op != OP_CREATE) begin
          state_d = S_FIND;
        end else if (stat_i.out_free) begin
          cmd_o.create = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_FIND: begin
        if (stat_i.found) begin
          cmd_o.find = 1'b1;
          state_d    = S_TOP;
        end else if (stat_i.out_free) begin
          cmd_o.emit_err   = 1'b1;
          cmd_o.err_status = ST_UNKNOWN;
          state_d          = S_IDLE;
        end
      end
      S_TOP: begin
        if (stat_i.op == OP_PUSH) begin
          if (stat_i.out_free) begin
            cmd_o.push = 1'b1;
            state_d    = S_IDLE;
          end
        end else if (!stat_i.top_null) begin
          cmd_o.list_start = 1'b1;
          state_d          = S_READ;
        end else if (stat_i.out_free) begin
          cmd_o.emit_err   = 1'b1;
          cmd_o.err_status = ST_EMPTY;
          state_d          = S_IDLE;
        end
      end
      S_READ: begin
        if (stat_i.out_free) begin
          if (stat_i.op == OP_POP) begin
            cmd_o.pop = 1'b1;
            state_d   = S_IDLE;
          end else begin
            cmd_o.list_emit = 1'b1;
            if (stat_i.walk_last) begin
              state_d = S_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/named_multi_stack_pool.sv */
// Top level of the named stack pool: controller plus datapath.
// Depends on msp_pkg, msp_req_if, msp_rsp_if, msp_ctrl and msp_datapath.
//
//   Port     Dir  Carries
//   req_i    in   operation, stack_name, item_in
//   rsp_o    out  status, item_out, last
//
// Steps: accept, tag compare, top-pointer read, node read. Create ends after the
// compare, unknown name after lookup, push or empty stack after the top read, pop
// after a node read; list walks the nodes while results are taken.
// Reset clears stack count, fresh node count, free list head and the result valid
// flag; the stores themselves are never cleared.
// A pending result stalls the controller only when it has the next one ready.
module named_multi_stack_pool import msp_pkg::*; #(
  parameter int MAX_STACKS = DEF_MAX_STACKS,
  parameter int POOL_DEPTH = DEF_POOL_DEPTH,
  parameter int ITEM_WIDTH = DEF_ITEM_WIDTH,
  parameter int NAME_WIDTH = DEF_NAME_WIDTH
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  msp_req_if.sink   req_i,
  msp_rsp_if.source rsp_o
);

  cmd_t  cmd;
  stat_t stat;

  // Sequencer
  msp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Storage and result register
  msp_datapath #(
    .MAX_STACKS (MAX_STACKS),
    .POOL_DEPTH (POOL_DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH),
    .NAME_WIDTH (NAME_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .req_operation_i  (req_i.operation),
    .req_stack_name_i (req_i.stack_name),
    .req_item_in_i    (req_i.item_in),
    .rsp_valid_o      (rsp_o.valid),
    .rsp_ready_i      (rsp_o.ready),
    .rsp_status_o     (rsp_o.status),
    .rsp_item_out_o   (rsp_o.item_out),
    .rsp_last_o       (rsp_o.last)
  );

endmodule
